// ===== hw/rtl/hsl_to_rgb_converter_defines.svh =====
// Assertion macros for the HSL to RGB converter checker.
// Self-contained; used by h2r_checker only.
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// Consequent must follow whenever the antecedent holds, outside reset.
`define H2R_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("h2r: implication failed");

// Expression must never be true outside reset.
`define H2R_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("h2r: forbidden condition seen");

`endif

// ===== hw/rtl/h2r_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // Pipeline depth from request to result strobe.
  localparam int PIPE_DEPTH = 6;

  // Hue band of one channel phase.
  typedef enum logic [1:0] {
    BAND_RISE,
    BAND_HIGH,
    BAND_FALL,
    BAND_LOW
  } band_t;

  // Phase offset of a channel: red leads, green centres, blue lags by a third.
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_CENTRE,
    PH_LAG
  } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/h2r_phase.sv =====
// Channel phase: offset and wrap the hue, then classify its band and slope.
// Two register stages. Depends on h2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2r_phase #(
  parameter int FRAC_BITS = 16,
  parameter h2r_pkg::phase_t PHASE = h2r_pkg::PH_CENTRE
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   hue,
  output h2r_pkg::band_t       band,
  output logic [FRAC_BITS:0]   slope
);
  import h2r_pkg::*;

  localparam int WS = FRAC_BITS + 3;
  localparam int WM = FRAC_BITS + 4;
  localparam logic [WS-1:0] ONE_S   = WS'(1 << FRAC_BITS);
  localparam logic [WS-1:0] THIRD_S = WS'((1 << FRAC_BITS) / 3);
  localparam logic [WM-1:0] ONE_M   = WM'(1 << FRAC_BITS);
  localparam logic [WM-1:0] TWO_M   = WM'(2 * (1 << FRAC_BITS));
  localparam logic [WM-1:0] SIX_TT_M = WM'(6 * ((2 * (1 << FRAC_BITS)) / 3));

  logic signed [WS-1:0] raw;
  logic signed [WS-1:0] wrapped;
  logic [FRAC_BITS:0]   t3;
  logic [FRAC_BITS:0]   t3_next;
  logic [WM-1:0]        t3x;
  logic [WM-1:0]        six;
  logic [WM-1:0]        two;
  logic [WM-1:0]        three;
  logic [WM-1:0]        m;
  band_t                band_next;
  logic [FRAC_BITS:0]   slope_next;

  always_comb begin
    case (PHASE)
      PH_LEAD: raw = $signed({2'b00, hue}) + $signed(THIRD_S);
      PH_LAG:  raw = $signed({2'b00, hue}) - $signed(THIRD_S);
      default: raw = $signed({2'b00, hue});
    endcase
    if (raw < 0) begin
      wrapped = raw + $signed(ONE_S);
    end else if (raw > $signed(ONE_S)) begin
      wrapped = raw - $signed(ONE_S);
    end else begin
      wrapped = raw;
    end
    t3_next = wrapped[FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    t3 <= t3_next;
  end

  always_comb begin
    t3x   = {3'b000, t3};
    six   = (t3x << 2) + (t3x << 1);
    two   = t3x << 1;
    three = (t3x << 1) + t3x;
    if (six < ONE_M) begin
      band_next = BAND_RISE;
      m         = six;
    end else if (two < ONE_M) begin
      band_next = BAND_HIGH;
      m         = '0;
    end else if (three < TWO_M) begin
      band_next = BAND_FALL;
      m         = SIX_TT_M - six;
    end else begin
      band_next = BAND_LOW;
      m         = '0;
    end
    slope_next = m[FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    band  <= band_next;
    slope <= slope_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/h2r_lightness.sv =====
// Lightness terms: t2, t1 and their difference at 2*FRAC_BITS fraction bits.
// Two register stages. Depends on h2r_pkg for house style only.
`timescale 1ns / 1ps
`default_nettype none

module h2r_lightness #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic [FRAC_BITS:0]     saturation,
  input  logic [FRAC_BITS:0]     lightness,
  output logic [2*FRAC_BITS:0]   t1,
  output logic [2*FRAC_BITS:0]   t2,
  output logic [2*FRAC_BITS:0]   diff
);
  import h2r_pkg::*;

  localparam int WX = 2 * FRAC_BITS + 2;

  logic [2*FRAC_BITS:0] ls;
  logic [2*FRAC_BITS:0] ls_next;
  logic [FRAC_BITS:0]   l_d;
  logic [FRAC_BITS:0]   s_d;
  logic                 low;
  logic                 low_next;
  logic [WX-1:0]        lw;
  logic [WX-1:0]        sw;
  logic [WX-1:0]        lsw;
  logic [WX-1:0]        t1x;
  logic [WX-1:0]        t2x;
  logic [WX-1:0]        dx;

  always_comb begin
    ls_next  = saturation * lightness;
    low_next = (lightness[FRAC_BITS:FRAC_BITS-1] == 2'b00);
  end

  always_ff @(posedge clk) begin
    ls  <= ls_next;
    l_d <= lightness;
    s_d <= saturation;
    low <= low_next;
  end

  always_comb begin
    lw  = {1'b0, l_d, {FRAC_BITS{1'b0}}};
    sw  = {1'b0, s_d, {FRAC_BITS{1'b0}}};
    lsw = {1'b0, ls};
    if (low) begin
      t2x = lw + lsw;
      t1x = lw - lsw;
      dx  = lsw << 1;
    end else begin
      t2x = lw + sw - lsw;
      t1x = lw - sw + lsw;
      dx  = (sw - lsw) << 1;
    end
  end

  always_ff @(posedge clk) begin
    t1   <= t1x[2*FRAC_BITS:0];
    t2   <= t2x[2*FRAC_BITS:0];
    diff <= dx[2*FRAC_BITS:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/h2r_channel.sv =====
// One colour channel: ramp products, level sum and scaling to 8 bits.
// Three register stages. Depends on h2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2r_channel #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  h2r_pkg::band_t         band,
  input  logic [FRAC_BITS:0]     slope,
  input  logic [2*FRAC_BITS:0]   t1,
  input  logic [2*FRAC_BITS:0]   t2,
  input  logic [2*FRAC_BITS:0]   diff,
  output logic [7:0]             level
);
  import h2r_pkg::*;

  localparam int WY = 3 * FRAC_BITS + 2;

  logic [2*FRAC_BITS:0]   base;
  logic [2*FRAC_BITS:0]   base_next;
  logic [2*FRAC_BITS+1:0] ph;
  logic [2*FRAC_BITS+1:0] ph_next;
  logic [2*FRAC_BITS:0]   pl;
  logic [2*FRAC_BITS:0]   pl_next;
  logic [WY-1:0]          sum;
  logic [3*FRAC_BITS:0]   y;
  logic [3*FRAC_BITS+8:0] scaled;

  always_comb begin
    base_next = (band == BAND_HIGH) ? t2 : t1;
    ph_next   = slope * diff[2*FRAC_BITS:FRAC_BITS];
    pl_next   = slope * diff[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    base <= base_next;
    ph   <= ph_next;
    pl   <= pl_next;
  end

  always_comb begin
    sum = {1'b0, base, {FRAC_BITS{1'b0}}}
        + {ph, {FRAC_BITS{1'b0}}}
        + {{(FRAC_BITS + 1){1'b0}}, pl};
  end

  always_ff @(posedge clk) begin
    y <= sum[3*FRAC_BITS:0];
  end

  always_comb begin
    scaled = {y, 8'h00} - {8'h00, y};
  end

  always_ff @(posedge clk) begin
    level <= scaled[3*FRAC_BITS+7:3*FRAC_BITS];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
// HSL to RGB pixel converter, top level.
// Depends on h2r_pkg, h2r_lightness, h2r_phase and h2r_channel.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is held low: a new pixel may be given in every cycle, so the block
//   converts one pixel per clock at full rate.
//   hue, saturation and lightness are unsigned with FRAC_BITS fraction bits;
//   values above 1.0 are clamped to 1.0 on entry.
//   The result (red, green, blue, each 8 bits, truncated) is shown for one
//   cycle with done high, once the request has passed the six register stages:
//   input clamp, phase wrap and l*s product, band decode and lightness terms,
//   ramp multipliers, level sum, and scaling into the output register.
//   The receiver cannot hold results off and need not: one result leaves per
//   cycle at most, in request order.
//   Synchronous reset clears the valid bits of every stage; pixels in flight
//   are dropped and done stays low until new requests reach the end.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAC_BITS:0]   hue,
  input  logic [FRAC_BITS:0]   saturation,
  input  logic [FRAC_BITS:0]   lightness,
  output logic                 done,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);
  import h2r_pkg::*;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld;
  logic [FRAC_BITS:0]    h_in;
  logic [FRAC_BITS:0]    s_in;
  logic [FRAC_BITS:0]    l_in;
  logic [2*FRAC_BITS:0]  t1;
  logic [2*FRAC_BITS:0]  t2;
  logic [2*FRAC_BITS:0]  diff;
  band_t                 band  [3];
  logic [FRAC_BITS:0]    slope [3];
  logic [7:0]            level [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    h_in <= (hue > ONE) ? ONE : hue;
    s_in <= (saturation > ONE) ? ONE : saturation;
    l_in <= (lightness > ONE) ? ONE : lightness;
  end

  h2r_lightness #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lightness (
    .clk        (clk),
    .saturation (s_in),
    .lightness  (l_in),
    .t1         (t1),
    .t2         (t2),
    .diff       (diff)
  );

  for (genvar i = 0; i < 3; i++) begin : g_chan
    h2r_phase #(
      .FRAC_BITS (FRAC_BITS),
      .PHASE     (phase_t'(i))
    ) u_phase (
      .clk   (clk),
      .hue   (h_in),
      .band  (band[i]),
      .slope (slope[i])
    );

    h2r_channel #(
      .FRAC_BITS (FRAC_BITS)
    ) u_channel (
      .clk   (clk),
      .band  (band[i]),
      .slope (slope[i]),
      .t1    (t1),
      .t2    (t2),
      .diff  (diff),
      .level (level[i])
    );
  end

  assign red   = level[0];
  assign green = level[1];
  assign blue  = level[2];

endmodule

`default_nettype wire

// ===== hw/rtl/h2r_checker.sv =====
// Port-level checker for the HSL to RGB converter, bound to the top level.
// Depends on h2r_pkg and hsl_to_rgb_converter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "hsl_to_rgb_converter_defines.svh"

module h2r_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import h2r_pkg::*;

  `H2R_ASSERT_NEVER(a_never_busy, clk, rst, busy)
  `H2R_ASSERT_IMPLY(a_request_gives_result, clk, rst, start && !busy, ##PIPE_DEPTH done)
  `H2R_ASSERT_IMPLY(a_result_has_request, clk, rst, done, $past(start && !busy, PIPE_DEPTH))
  `H2R_ASSERT_IMPLY(a_quiet_after_reset, clk, rst, $past(rst), !done)

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

// ===== tb/tb_hsl_to_rgb_converter.sv =====
// Self-checking testbench for hsl_to_rgb_converter: directed corner pixels, then random
// HSL requests with random sender gaps, each result compared with an in-bench predictor.
// Depends on h2r_pkg and the hsl_to_rgb_converter RTL.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;

  localparam int     FB          = 16;
  localparam longint UNIT        = 65536;
  localparam longint THIRD       = UNIT / 3;
  localparam longint TWO_THIRD   = (2 * UNIT) / 3;
  localparam int     N_RANDOM    = 1800;
  localparam int     QUIET_LIMIT = 1000;

  typedef struct {
    logic [FB:0] h, s, l;
    int          gap;
    bit          drain;
  } pixel_req_t;

  typedef struct {
    logic [FB:0] h, s, l;
    logic [7:0]  r, g, b;
  } pixel_due_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [FB:0] hue = '0;
  logic [FB:0] saturation = '0;
  logic [FB:0] lightness = '0;
  logic        busy, done;
  logic [7:0]  red, green, blue;

  pixel_req_t  pending[$];
  pixel_due_t  rgb_due[$];
  pixel_req_t  staged;
  bit          staged_ok = 0;
  int          hold_left = 0;
  logic        took = 1'b0;
  int          quiet = 0;
  int          n_total = 0;
  int          n_directed = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_errors = 0;

  hsl_to_rgb_converter #(.FRAC_BITS(FB)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] clamp_unit(logic [FB:0] v);
    return (v > UNIT) ? UNIT : v;
  endfunction

  // lo_w and hi_w carry 2*FB fraction bits; ph is the unwrapped channel phase
  function automatic logic [7:0] channel_byte(logic [63:0] lo_w, logic [63:0] hi_w,
                                              longint ph);
    logic [63:0] t3, u, k, diff, term, flat, acc;
    bit          ramp;
    if (ph < 0) ph = ph + UNIT;
    else if (ph > UNIT) ph = ph - UNIT;
    t3   = ph;
    ramp = 1;
    u    = 0;
    flat = lo_w;
    if (6 * t3 < UNIT) begin
      u = t3;
    end else if (2 * t3 < UNIT) begin
      ramp = 0;
      flat = hi_w;
    end else if (3 * t3 < 2 * UNIT) begin
      u = TWO_THIRD - t3;
    end else begin
      ramp = 0;
    end
    if (ramp) begin
      k    = 6 * u * 255;
      diff = hi_w - lo_w;
      term = (diff >> FB) * k + (((diff & (UNIT - 1)) * k) >> FB);
      acc  = (255 * lo_w + term) >> (2 * FB);
    end else begin
      acc = (255 * flat) >> (2 * FB);
    end
    return acc[7:0];
  endfunction

  function automatic pixel_due_t convert_hsl(logic [FB:0] hue_in, logic [FB:0] sat_in,
                                             logic [FB:0] lit_in);
    logic [63:0] h, s, l, lo_w, hi_w;
    pixel_due_t  px;
    h = clamp_unit(hue_in);
    s = clamp_unit(sat_in);
    l = clamp_unit(lit_in);
    if (2 * l < UNIT) hi_w = l * (UNIT + s);
    else hi_w = l * UNIT + s * UNIT - l * s;
    lo_w = 2 * l * UNIT - hi_w;
    px.h = hue_in;
    px.s = sat_in;
    px.l = lit_in;
    px.r = channel_byte(lo_w, hi_w, $signed(h) + THIRD);
    px.g = channel_byte(lo_w, hi_w, $signed(h));
    px.b = channel_byte(lo_w, hi_w, $signed(h) - THIRD);
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_channel(input string name, input pixel_due_t want,
                               input logic [7:0] want_v, input logic [7:0] got_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s h=%0d s=%0d l=%0d: expected %0d, got %0d",
                                name, want.h, want.s, want.l, want_v, got_v));
  endtask

  task automatic queue_pixel(input int h, input int s, input int l, input int gap,
                             input bit drain);
    pixel_req_t rq;
    rq.h     = h[FB:0];
    rq.s     = s[FB:0];
    rq.l     = l[FB:0];
    rq.gap   = gap;
    rq.drain = drain;
    pending.push_back(rq);
  endtask

  function automatic logic [FB:0] random_field();
    logic [31:0] raw;
    int unsigned sel;
    sel = $urandom_range(99);
    raw = $urandom;
    if (sel < 55) return (FB + 1)'($urandom_range(65536));
    if (sel < 80) return raw[FB:0];
    case ($urandom_range(12))
      0:       return 0;
      1:       return 1;
      2:       return 10922;
      3:       return 10923;
      4:       return 21844;
      5:       return 21845;
      6:       return 21846;
      7:       return 32767;
      8:       return 32768;
      9:       return 43690;
      10:      return 43691;
      11:      return 65535;
      default: return 65536;
    endcase
  endfunction

  // Driver: present the next request at the falling edge, honouring its gap and drain.
  always @(negedge clk) begin
    bit present;
    if (rst) begin
      start     <= 1'b0;
      staged_ok = 0;
      hold_left = 0;
    end else begin
      present = start && !took;
      if (!present) begin
        if (!staged_ok && pending.size() != 0) begin
          staged    = pending.pop_front();
          staged_ok = 1;
          hold_left = staged.gap;
        end
        if (staged_ok) begin
          if (hold_left != 0) begin
            hold_left--;
          end else if (!staged.drain || rgb_due.size() == 0) begin
            present    = 1;
            staged_ok  = 0;
            hue        <= staged.h;
            saturation <= staged.s;
            lightness  <= staged.l;
          end
        end
      end
      start <= present;
    end
  end

  // Monitor: check results, record accepted requests, run the watchdog.
  always @(posedge clk) begin
    pixel_due_t want;
    if (rst) begin
      took  <= 1'b0;
      quiet <= 0;
    end else begin
      if (done) begin
        if (rgb_due.size() == 0) begin
          report_mismatch($sformatf("result r=%0d g=%0d b=%0d with no request outstanding",
                                    red, green, blue));
        end else begin
          want = rgb_due.pop_front();
          check_channel("red", want, want.r, red);
          check_channel("green", want, want.g, green);
          check_channel("blue", want, want.b, blue);
          n_checked++;
        end
      end
      if (start && !busy) begin
        rgb_due.push_back(convert_hsl(hue, saturation, lightness));
        n_accepted++;
      end
      took <= start && !busy;
      if (done || (start && !busy)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: no request or result for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    bit no_gaps;
    int gap;
    // corners: extremes, clamping, lightness split, band edges, phase wrap and phase of one
    queue_pixel(0, 0, 0, 0, 0);
    queue_pixel(65536, 65536, 65536, 0, 0);
    queue_pixel(131071, 131071, 131071, 1, 0);
    queue_pixel(65537, 40000, 30000, 0, 0);
    queue_pixel(0, 65536, 32768, 2, 0);
    queue_pixel(21845, 65536, 32768, 0, 0);
    queue_pixel(43690, 65536, 32768, 0, 0);
    queue_pixel(10000, 65536, 32767, 0, 0);
    queue_pixel(10000, 30000, 32768, 3, 0);
    queue_pixel(43691, 50000, 20000, 0, 0);
    queue_pixel(65536, 50000, 40000, 0, 0);
    queue_pixel(10922, 45000, 25000, 0, 0);
    queue_pixel(10923, 45000, 25000, 1, 0);
    queue_pixel(32767, 60000, 45000, 0, 0);
    queue_pixel(32768, 60000, 45000, 0, 0);
    queue_pixel(43690, 20000, 50000, 0, 0);
    queue_pixel(21844, 55000, 30000, 0, 0);
    queue_pixel(50000, 55000, 30000, 8, 0);
    queue_pixel(5000, 0, 12345, 0, 0);
    queue_pixel(30000, 65536, 0, 0, 0);
    queue_pixel(77777, 65535, 1, 0, 1);
    queue_pixel(1, 1, 65535, 0, 0);
    n_directed = pending.size();

    no_gaps = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(2) == 0);
      gap = no_gaps ? 0 : $urandom_range(8);
      queue_pixel(int'(random_field()), int'(random_field()), int'(random_field()), gap,
                  (i % 450) == 449);
    end
    n_total = pending.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted != n_total) @(posedge clk);
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (h2r_pkg::PIPE_DEPTH + 4) @(posedge clk);

    $display("Converted %0d pixels: %0d directed corners, then random HSL incl. clamped inputs",
             n_total, n_directed);
    $display("Compared %0d results under random sender gaps, bursts and drain pauses",
             n_checked);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
